// File: hdl/assert_macros.svh
// Assertion macros used by the port-level checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define CRSS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
    else $error("assertion failed");

// Clocked assertion that also holds during reset.
`define CRSS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

// File: hdl/crss_pkg.sv
// Shared types and codes of the register slave session.
// No dependencies.
package crss_pkg;

  typedef enum logic [2:0] {
    FC_WR_RANGE  = 3'd0,
    FC_WR_SERIES = 3'd1,
    FC_RD_RANGE  = 3'd2,
    FC_RD_SERIES = 3'd3
  } crss_func_e;

  typedef enum logic [1:0] {
    MT_MASTER    = 2'd0,
    MT_MASTER_HP = 2'd1,
    MT_SLAVE     = 2'd2,
    MT_SLAVE_HP  = 2'd3
  } crss_msg_e;

  typedef enum logic [1:0] {
    LINK_NONE     = 2'd0,
    LINK_LOST     = 2'd1,
    LINK_RESTORED = 2'd2
  } crss_link_e;

  localparam logic [2:0] CFG_OWN_ADDR   = 3'd0;
  localparam logic [2:0] CFG_BCAST_ADDR = 3'd1;
  localparam logic [2:0] CFG_DIRECT     = 3'd2;
  localparam logic [2:0] CFG_TIMEOUT    = 3'd3;
  localparam logic [2:0] CFG_VALID_CNT  = 3'd4;
  localparam logic [2:0] CFG_FIRST_WR   = 3'd5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHK,
    ST_RUN,
    ST_DONE
  } crss_state_e;

  typedef struct packed {
    logic [5:0]  own_addr;
    logic [5:0]  bcast_addr;
    logic [5:0]  direct_addr;
    logic [31:0] timeout;
    logic [8:0]  valid_cnt;
    logic [8:0]  first_wr;
  } crss_cfg_t;

  // Outcome of the command check: pass flag, access count, answer length, header bytes.
  typedef struct packed {
    logic            ok;
    logic [2:0]      n_acc;
    logic [3:0]      alen;
    logic [7:0][7:0] hdr;
  } crss_plan_t;

endpackage

// File: hdl/can_register_slave_session_core.sv
// Top level of the register slave session: configuration registers, register store.
// Depends on crss_pkg, crss_ram and crss_ctrl.
//
// Usage:
//  - Items: drive the item fields and raise start; the item is taken at a
//    rising edge with start high and busy low. busy stays high until the
//    result has been shown.
//  - Results: exactly one per item, on the answer/link ports for one cycle
//    with result_valid_o high. The receiver cannot stall; it must take the
//    transfer in that cycle.
//  - Sequence: the item is captured, checked in ST_CHK, its registers are
//    accessed in order in ST_RUN (none for idle polls, ignored frames, nacks
//    and peer frames), reads waiting for the store's registered read, and the
//    result is shown in ST_DONE.
//  - Throughput: busy drops in the cycle after the result, so a new item is
//    taken only once the last result has been shown. The store has one
//    write and one read port; one register a cycle.
//  - Configuration: write transfers on cfg_valid_i/cfg_ready_o, always ready;
//    indexes 6 and 7 are ignored. Write only while busy is low.
//  - Reset: all configuration back to defaults, link disconnected, last
//    request time zero. The store reads as zero per register until written
//    (a flop per register marks it), so no clearing pass is needed.
module can_register_slave_session_core #(
  parameter int REG_COUNT       = 256,
  parameter int MAX_RANGE_REGS  = 6,
  parameter int MAX_SERIES_REGS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        start,
  output logic        busy,
  input  logic        kind_i,
  input  logic [31:0] now_time_i,
  input  logic [5:0]  dest_address_i,
  input  logic [2:0]  func_code_i,
  input  logic [1:0]  msg_type_i,
  input  logic [3:0]  data_len_i,
  input  logic [63:0] payload_i,
  output logic        result_valid_o,
  output logic        answer_valid_o,
  output logic [5:0]  answer_address_o,
  output logic [2:0]  answer_func_code_o,
  output logic [3:0]  answer_length_o,
  output logic [63:0] answer_payload_o,
  output logic [1:0]  link_event_o,
  output logic        frame_taken_o,
  output logic        peer_frame_o
);
  import crss_pkg::*;

  localparam int AW = $clog2(REG_COUNT);

  crss_cfg_t cfg_q;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;

  assign cfg_ready_o = 1'b1;

  // Configuration register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.own_addr    <= 6'd1;
      cfg_q.bcast_addr  <= 6'd0;
      cfg_q.direct_addr <= 6'd63;
      cfg_q.timeout     <= 32'd1000;
      cfg_q.valid_cnt   <= 9'd256;
      cfg_q.first_wr    <= 9'd0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_OWN_ADDR:   cfg_q.own_addr    <= cfg_data_i[5:0];
        CFG_BCAST_ADDR: cfg_q.bcast_addr  <= cfg_data_i[5:0];
        CFG_DIRECT:     cfg_q.direct_addr <= cfg_data_i[5:0];
        CFG_TIMEOUT:    cfg_q.timeout     <= cfg_data_i;
        CFG_VALID_CNT:  cfg_q.valid_cnt   <= cfg_data_i[8:0];
        CFG_FIRST_WR:   cfg_q.first_wr    <= cfg_data_i[8:0];
        default:        ;
      endcase
    end
  end

  // Register store
  crss_ram #(
    .WIDTH(8),
    .DEPTH(REG_COUNT)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  crss_ctrl #(
    .REG_COUNT      (REG_COUNT),
    .MAX_RANGE_REGS (MAX_RANGE_REGS),
    .MAX_SERIES_REGS(MAX_SERIES_REGS)
  ) u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg_q),
    .start             (start),
    .busy              (busy),
    .kind_i            (kind_i),
    .now_time_i        (now_time_i),
    .dest_address_i    (dest_address_i),
    .func_code_i       (func_code_i),
    .msg_type_i        (msg_type_i),
    .data_len_i        (data_len_i),
    .payload_i         (payload_i),
    .ram_we_o          (ram_we),
    .ram_waddr_o       (ram_waddr),
    .ram_wdata_o       (ram_wdata),
    .ram_raddr_o       (ram_raddr),
    .ram_rdata_i       (ram_rdata),
    .result_valid_o    (result_valid_o),
    .answer_valid_o    (answer_valid_o),
    .answer_address_o  (answer_address_o),
    .answer_func_code_o(answer_func_code_o),
    .answer_length_o   (answer_length_o),
    .answer_payload_o  (answer_payload_o),
    .link_event_o      (link_event_o),
    .frame_taken_o     (frame_taken_o),
    .peer_frame_o      (peer_frame_o)
  );
endmodule

// File: hdl/crss_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module crss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// File: hdl/crss_cmd.sv
// Command checker: validates length and register numbers, builds answer header.
// Depends on crss_pkg.
module crss_cmd #(
  parameter int REG_COUNT       = 256,
  parameter int MAX_RANGE_REGS  = 6,
  parameter int MAX_SERIES_REGS = 4
) (
  input  logic [2:0]           fc_i,
  input  logic [3:0]           len_i,
  input  logic [63:0]          pl_i,
  input  crss_pkg::crss_cfg_t  cfg_i,
  output crss_pkg::crss_plan_t plan_o
);
  import crss_pkg::*;

  logic [7:0][7:0] b;
  logic [7:0]      start_b, end_b, total;
  logic            len_ok, rng_wr_all, rng_rd_all, ser_wr_all, ser_rd_all;
  logic [7:0][7:0] ser_wr_hdr, ser_rd_hdr;

  function automatic logic f_exists(logic [9:0] r, logic [8:0] vcnt);
    return (r < {1'b0, vcnt}) && (r < 10'(REG_COUNT));
  endfunction

  assign b       = pl_i;
  assign start_b = b[0];
  assign end_b   = b[1];
  assign total   = 8'(end_b - start_b + 8'd1);
  assign len_ok  = len_i <= 4'd8;

  always_comb begin
    logic [9:0] r;
    rng_wr_all = 1'b1;
    rng_rd_all = 1'b1;
    ser_wr_all = 1'b1;
    ser_rd_all = 1'b1;
    ser_wr_hdr = '0;
    ser_rd_hdr = '0;
    for (int i = 0; i < MAX_RANGE_REGS; i++) begin
      r = {2'b00, start_b} + 10'(i);
      if (8'(i) < total) begin
        if (!f_exists(r, cfg_i.valid_cnt)) begin
          rng_rd_all = 1'b0;
        end
        if (!f_exists(r, cfg_i.valid_cnt) || (r < {1'b0, cfg_i.first_wr})) begin
          rng_wr_all = 1'b0;
        end
      end
    end
    for (int k = 0; k < 4; k++) begin
      if (4'(2 * k) < len_i) begin
        r = {2'b00, b[2*k]};
        ser_wr_hdr[k] = b[2*k];
        if (!f_exists(r, cfg_i.valid_cnt) || (r < {1'b0, cfg_i.first_wr})) begin
          ser_wr_all = 1'b0;
        end
      end
      if (4'(k) < len_i) begin
        r = {2'b00, b[k]};
        ser_rd_hdr[2*k] = b[k];
        if (!f_exists(r, cfg_i.valid_cnt)) begin
          ser_rd_all = 1'b0;
        end
      end
    end
  end

  always_comb begin
    plan_o = '0;
    case (fc_i)
      FC_WR_RANGE: begin
        plan_o.ok = len_ok && (9'(len_i) == 9'(total) + 9'd2) && (end_b >= start_b)
                    && (total <= 8'(MAX_RANGE_REGS)) && rng_wr_all;
        plan_o.n_acc  = 3'(total);
        plan_o.alen   = 4'd2;
        plan_o.hdr[0] = start_b;
        plan_o.hdr[1] = end_b;
      end
      FC_WR_SERIES: begin
        plan_o.ok    = len_ok && !len_i[0] && ser_wr_all;
        plan_o.n_acc = len_i[3:1];
        plan_o.alen  = {1'b0, len_i[3:1]};
        plan_o.hdr   = ser_wr_hdr;
      end
      FC_RD_RANGE: begin
        plan_o.ok = len_ok && (len_i == 4'd2) && (end_b >= start_b)
                    && (total <= 8'(MAX_RANGE_REGS)) && rng_rd_all;
        plan_o.n_acc  = 3'(total);
        plan_o.alen   = 4'(total) + 4'd2;
        plan_o.hdr[0] = start_b;
        plan_o.hdr[1] = end_b;
      end
      FC_RD_SERIES: begin
        plan_o.ok = len_ok && (len_i <= 4'(MAX_SERIES_REGS)) && (len_i <= 4'd4)
                    && (len_i != 4'd0) && ser_rd_all;
        plan_o.n_acc = 3'(len_i);
        plan_o.alen  = {len_i[2:0], 1'b0};
        plan_o.hdr   = ser_rd_hdr;
      end
      default: plan_o = '0;
    endcase
    if (!plan_o.ok) begin
      plan_o = '0;
    end
  end
endmodule

// File: hdl/crss_ctrl.sv
// Session sequencer: item capture, link tracking, register access and result.
// Depends on crss_pkg and crss_cmd.
module crss_ctrl #(
  parameter int REG_COUNT       = 256,
  parameter int MAX_RANGE_REGS  = 6,
  parameter int MAX_SERIES_REGS = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  crss_pkg::crss_cfg_t          cfg_i,
  input  logic                         start,
  output logic                         busy,
  input  logic                         kind_i,
  input  logic [31:0]                  now_time_i,
  input  logic [5:0]                   dest_address_i,
  input  logic [2:0]                   func_code_i,
  input  logic [1:0]                   msg_type_i,
  input  logic [3:0]                   data_len_i,
  input  logic [63:0]                  payload_i,
  output logic                         ram_we_o,
  output logic [$clog2(REG_COUNT)-1:0] ram_waddr_o,
  output logic [7:0]                   ram_wdata_o,
  output logic [$clog2(REG_COUNT)-1:0] ram_raddr_o,
  input  logic [7:0]                   ram_rdata_i,
  output logic                         result_valid_o,
  output logic                         answer_valid_o,
  output logic [5:0]                   answer_address_o,
  output logic [2:0]                   answer_func_code_o,
  output logic [3:0]                   answer_length_o,
  output logic [63:0]                  answer_payload_o,
  output logic [1:0]                   link_event_o,
  output logic                         frame_taken_o,
  output logic                         peer_frame_o
);
  import crss_pkg::*;

  localparam int AW = $clog2(REG_COUNT);

  crss_state_e state_q, state_d;

  logic        kind_q;
  logic [31:0] now_q;
  logic [5:0]  addr_q;
  logic [2:0]  fc_q;
  logic [1:0]  mt_q;
  logic [3:0]  len_q;
  logic [63:0] pl_q;

  logic        conn_q, conn_d;
  logic [31:0] last_q, last_d;
  logic [1:0]  link_q, link_d;
  logic        taken_q, peer_q, ansv_q;
  logic [5:0]  aaddr_q;
  logic [3:0]  alen_q;
  logic [7:0][7:0] ans_q;
  logic [2:0]  n_q, idx_q;
  logic        is_wr_q;
  logic        pend_q;
  logic [2:0]  pend_pos_q;
  logic        rd_vld_q;
  logic [REG_COUNT-1:0] reg_vld_q;

  crss_plan_t  plan;
  logic        is_master, ours, lost, taken, peer, run_cmd, ansv;
  logic        do_acc;
  logic [8:0]  acc_reg;
  logic [2:0]  wsel, rpos;

  crss_cmd #(
    .REG_COUNT      (REG_COUNT),
    .MAX_RANGE_REGS (MAX_RANGE_REGS),
    .MAX_SERIES_REGS(MAX_SERIES_REGS)
  ) u_cmd (
    .fc_i  (fc_q),
    .len_i (len_q),
    .pl_i  (pl_q),
    .cfg_i (cfg_i),
    .plan_o(plan)
  );

  assign is_master = (mt_q == MT_MASTER) || (mt_q == MT_MASTER_HP);
  assign ours      = (addr_q == cfg_i.own_addr) || (addr_q == cfg_i.bcast_addr)
                     || (addr_q == cfg_i.direct_addr);
  assign lost      = kind_q && ((now_q - last_q) > cfg_i.timeout) && conn_q;
  assign taken     = !kind_q && !(!ours && is_master);
  assign peer      = taken && (mt_q == MT_SLAVE_HP);
  assign run_cmd   = taken && !peer && plan.ok;
  assign ansv      = taken && is_master && (addr_q != cfg_i.bcast_addr);

  // Per-access register number, write byte and answer slot.
  always_comb begin
    case (fc_q)
      FC_WR_RANGE, FC_RD_RANGE: acc_reg = {1'b0, pl_q[7:0]} + 9'(idx_q);
      FC_WR_SERIES:             acc_reg = {1'b0, pl_q[{idx_q[1:0], 1'b0, 3'b000} +: 8]};
      default:                  acc_reg = {1'b0, pl_q[{idx_q, 3'b000} +: 8]};
    endcase
    wsel = (fc_q == FC_WR_RANGE) ? 3'(idx_q + 3'd2) : {idx_q[1:0], 1'b1};
    rpos = (fc_q == FC_RD_RANGE) ? 3'(idx_q + 3'd2) : {idx_q[1:0], 1'b1};
  end

  assign do_acc      = (state_q == ST_RUN) && (idx_q < n_q);
  assign ram_we_o    = do_acc && is_wr_q;
  assign ram_waddr_o = acc_reg[AW-1:0];
  assign ram_wdata_o = pl_q[{wsel, 3'b000} +: 8];
  assign ram_raddr_o = acc_reg[AW-1:0];

  always_comb begin
    state_d = state_q;
    conn_d  = conn_q;
    last_d  = last_q;
    link_d  = link_q;
    case (state_q)
      ST_IDLE: if (start) state_d = ST_CHK;
      ST_CHK: begin
        state_d = ST_RUN;
        link_d  = LINK_NONE;
        if (lost) begin
          conn_d = 1'b0;
          link_d = LINK_LOST;
        end
        if (taken) begin
          last_d = now_q;
          if (!conn_q) begin
            conn_d = 1'b1;
            link_d = LINK_RESTORED;
          end
        end
      end
      ST_RUN:  if (!do_acc && !pend_q) state_d = ST_DONE;
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      conn_q    <= 1'b0;
      last_q    <= '0;
      link_q    <= LINK_NONE;
      idx_q     <= '0;
      n_q       <= '0;
      pend_q    <= 1'b0;
      reg_vld_q <= '0;
    end else begin
      state_q <= state_d;
      conn_q  <= conn_d;
      last_q  <= last_d;
      link_q  <= link_d;
      pend_q  <= do_acc && !is_wr_q;
      if (state_q == ST_CHK) begin
        idx_q <= '0;
        n_q   <= run_cmd ? plan.n_acc : 3'd0;
      end else if (do_acc) begin
        idx_q <= idx_q + 3'd1;
      end
      if (ram_we_o) begin
        reg_vld_q[ram_waddr_o] <= 1'b1;
      end
    end
  end

  // Item and answer payload.
  always_ff @(posedge clk_i) begin
    if (start && state_q == ST_IDLE) begin
      kind_q <= kind_i;
      now_q  <= now_time_i;
      addr_q <= dest_address_i;
      fc_q   <= func_code_i;
      mt_q   <= msg_type_i;
      len_q  <= data_len_i;
      pl_q   <= payload_i;
    end
    if (state_q == ST_CHK) begin
      taken_q <= taken;
      peer_q  <= peer;
      ansv_q  <= ansv;
      aaddr_q <= (addr_q == cfg_i.direct_addr) ? cfg_i.own_addr : addr_q;
      alen_q  <= run_cmd ? plan.alen : 4'd0;
      ans_q   <= run_cmd ? plan.hdr : '0;
      is_wr_q <= (fc_q == FC_WR_RANGE) || (fc_q == FC_WR_SERIES);
    end
    rd_vld_q   <= reg_vld_q[ram_raddr_o];
    pend_pos_q <= rpos;
    if (pend_q) begin
      ans_q[pend_pos_q] <= rd_vld_q ? ram_rdata_i : 8'd0;
    end
  end

  assign busy               = (state_q != ST_IDLE);
  assign result_valid_o     = (state_q == ST_DONE);
  assign answer_valid_o     = ansv_q;
  assign answer_address_o   = ansv_q ? aaddr_q : 6'd0;
  assign answer_func_code_o = ansv_q ? fc_q : 3'd0;
  assign answer_length_o    = ansv_q ? alen_q : 4'd0;
  assign answer_payload_o   = ansv_q ? ans_q : 64'd0;
  assign link_event_o       = link_q;
  assign frame_taken_o      = taken_q;
  assign peer_frame_o       = peer_q;
endmodule

// File: hdl/crss_chk.sv
// Port-level checker for the register slave session, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module crss_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       result_valid_o,
  input logic       answer_valid_o,
  input logic [3:0] answer_length_o,
  input logic [1:0] link_event_o,
  input logic       frame_taken_o,
  input logic       peer_frame_o
);
  `CRSS_ASSERT(a_take_busy, clk_i, rst_ni, (start && !busy) |=> busy)
  `CRSS_ASSERT(a_result_busy, clk_i, rst_ni, result_valid_o |-> busy)
  `CRSS_ASSERT(a_result_frees, clk_i, rst_ni, result_valid_o |=> !busy)
  `CRSS_ASSERT(a_nack_fields, clk_i, rst_ni,
               (result_valid_o && !answer_valid_o) |-> (answer_length_o == 4'd0))
  `CRSS_ASSERT(a_peer_taken, clk_i, rst_ni,
               (result_valid_o && (peer_frame_o || answer_valid_o)) |-> frame_taken_o)
endmodule

bind can_register_slave_session_core crss_chk u_crss_chk (.*);
